// File: rtl/efcd_pkg.sv
// ----------------------------------------------------------------------------
// efcd_pkg
// Shared constants, register codes and types of the escaped frame color
// command decoder.
// ----------------------------------------------------------------------------
package efcd_pkg;

  // Depth of the frame store; write index counts up to FRAME_DEPTH-1
  localparam int unsigned FRAME_DEPTH = 64;
  localparam int unsigned IDX_W       = (FRAME_DEPTH > 2) ? $clog2(FRAME_DEPTH) : 1;

  // Frame bytes that decoding looks at: type, opcode, red, green, blue
  localparam int unsigned HEAD_BYTES  = 5;

  // Decode queue between front and back
  localparam int unsigned Q_DEPTH     = 2;
  localparam int unsigned Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W     = $clog2(Q_DEPTH + 1);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W   = 3;
  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_BYTE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REQUEST_TYPE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_OPCODE = 3'd4;

  typedef logic [7:0] byte_t;

  // Register reset values
  localparam byte_t RST_START_BYTE   = 8'd2;
  localparam byte_t RST_ESCAPE_BYTE  = 8'd27;
  localparam byte_t RST_END_BYTE     = 8'd3;
  localparam byte_t RST_REQUEST_TYPE = 8'd1;
  localparam byte_t RST_COLOR_OPCODE = 8'd1;

  // Head bytes by frame position
  localparam int unsigned POS_TYPE   = 0;
  localparam int unsigned POS_OPCODE = 1;
  localparam int unsigned POS_RED    = 2;
  localparam int unsigned POS_GREEN  = 3;
  localparam int unsigned POS_BLUE   = 4;

  typedef struct packed {
    byte_t start_byte;
    byte_t escape_byte;
    byte_t end_byte;
    byte_t request_type;
    byte_t color_opcode;
  } cfg_t;

  typedef byte_t [HEAD_BYTES-1:0] head_t;

  // Front to queue: push a closed frame's head bytes
  typedef struct packed {
    logic  push;
    head_t head;
  } q_wr_t;

  // Queue to back: oldest closed frame
  typedef struct packed {
    logic  valid;
    head_t head;
  } q_rd_t;

  // Queue occupancy seen by front and top
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  // Front framing state
  typedef struct packed {
    logic in_frame;
    logic esc_pending;
  } front_stat_t;

endpackage

// File: rtl/efcd_intf.sv
// ----------------------------------------------------------------------------
// efcd channel interfaces
// Valid/ready channels for received bytes, color results and register writes.
// ----------------------------------------------------------------------------
interface efcd_byte_if;
  import efcd_pkg::*;
  logic  valid;
  logic  ready;
  byte_t rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efcd_color_if;
  import efcd_pkg::*;
  logic  valid;
  logic  ready;
  byte_t red_level;
  byte_t green_level;
  byte_t blue_level;
  modport source (output valid, output red_level, output green_level,
                  output blue_level, input ready);
  modport sink   (input valid, input red_level, input green_level,
                  input blue_level, output ready);
endinterface

interface efcd_cfg_if;
  import efcd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] wr_index;
  byte_t                wr_data;
  modport source (output valid, output wr_index, output wr_data, input ready);
  modport sink   (input valid, input wr_index, input wr_data, output ready);
endinterface

// File: rtl/escaped_frame_color_command_decoder.sv
// ----------------------------------------------------------------------------
// escaped_frame_color_command_decoder
// Byte-stuffed frame receiver that decodes set-color requests.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle. Outside a frame every byte but the
// start byte is ignored; inside, the escape byte makes the next byte literal
// and the end byte closes the frame. Data beyond one short of the store depth
// is dropped, and the store is never cleared between frames, so a short frame
// decodes bytes left over from earlier ones (reset clears them to zero). When
// a closed frame carries the request type in byte 0 and the color opcode in
// byte 1, bytes 2 to 4 go out as one red/green/blue item from the result
// register. Closed frames wait in a two-entry decode queue, so
// the byte input stalls only while that queue is full, which happens only
// when the color output is held off. Registers are written through the
// configuration channel, which is always ready; write them only while idle.
// ----------------------------------------------------------------------------
module escaped_frame_color_command_decoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  efcd_byte_if.sink    rx_if,
  efcd_color_if.source color_if,
  efcd_cfg_if.sink     cfg_if
);
  import efcd_pkg::*;

  cfg_t        cfg_q;
  q_wr_t       q_wr;
  q_rd_t       q_rd;
  q_stat_t     q_stat;
  front_stat_t front_stat;
  logic        pop;
  logic        rx_ready;
  logic        rx_accept;

  // Register file: writes to unknown indexes are dropped
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte   <= RST_START_BYTE;
      cfg_q.escape_byte  <= RST_ESCAPE_BYTE;
      cfg_q.end_byte     <= RST_END_BYTE;
      cfg_q.request_type <= RST_REQUEST_TYPE;
      cfg_q.color_opcode <= RST_COLOR_OPCODE;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.wr_index)
        REG_START_BYTE:   cfg_q.start_byte   <= cfg_if.wr_data;
        REG_ESCAPE_BYTE:  cfg_q.escape_byte  <= cfg_if.wr_data;
        REG_END_BYTE:     cfg_q.end_byte     <= cfg_if.wr_data;
        REG_REQUEST_TYPE: cfg_q.request_type <= cfg_if.wr_data;
        REG_COLOR_OPCODE: cfg_q.color_opcode <= cfg_if.wr_data;
        default: begin
        end
      endcase
    end
  end

  // Front: framing, escapes and head-byte store
  efcd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (rx_if.valid),
    .in_ready_o (rx_ready),
    .rx_byte_i  (rx_if.rx_byte),
    .q_stat_i   (q_stat),
    .q_wr_o     (q_wr),
    .stat_o     (front_stat)
  );

  assign rx_if.ready = rx_ready;
  assign rx_accept   = rx_if.valid && rx_ready;

  // Decode queue: lets the front keep taking bytes while a result waits
  efcd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_wr_i   (q_wr),
    .pop_i    (pop),
    .q_rd_o   (q_rd),
    .q_stat_o (q_stat)
  );

  // Back: match type and opcode, hold the color result
  efcd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_rd_i        (q_rd),
    .pop_o         (pop),
    .out_valid_o   (color_if.valid),
    .out_ready_i   (color_if.ready),
    .red_level_o   (color_if.red_level),
    .green_level_o (color_if.green_level),
    .blue_level_o  (color_if.blue_level)
  );

`ifndef ASSERT_OFF
  // A closed frame always lands in the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr.push |=> q_stat.valid)
    else $error("closed frame lost before decode queue");

  // A new result only comes from a queued frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(color_if.valid) |-> $past(q_rd.valid))
    else $error("color result without a queued frame");

  // Outside a frame only the start byte opens one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_accept && !front_stat.in_frame && (rx_if.rx_byte != cfg_q.start_byte))
      |=> !front_stat.in_frame)
    else $error("frame opened by a byte other than the start byte");

  // No escape can be pending outside a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !front_stat.in_frame |-> !front_stat.esc_pending)
    else $error("escape pending while idle");
`endif

endmodule

// File: rtl/efcd_front.sv
// ----------------------------------------------------------------------------
// efcd_front
// Accepts received bytes, tracks framing and escapes, stores frame head bytes
// and pushes a closed frame into the decode queue.
// ----------------------------------------------------------------------------
module efcd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  efcd_pkg::cfg_t        cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  efcd_pkg::byte_t       rx_byte_i,
  input  efcd_pkg::q_stat_t     q_stat_i,
  output efcd_pkg::q_wr_t       q_wr_o,
  output efcd_pkg::front_stat_t stat_o
);
  import efcd_pkg::*;

  logic             in_frame_q, in_frame_d;
  logic             esc_q, esc_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  head_t            head_q, head_d;
  logic             accept;
  logic             store_data;
  logic             store_end;
  logic             wr_en;

  // Stall whenever the decode queue is full, so a closed frame could not be queued
  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    idx_d      = idx_q;
    head_d     = head_q;
    store_data = 1'b0;
    store_end  = 1'b0;
    wr_en      = 1'b0;
    if (accept) begin
      if (!in_frame_q) begin
        if (rx_byte_i == cfg_i.start_byte) begin
          in_frame_d = 1'b1;
        end
      end else if (esc_q) begin
        esc_d      = 1'b0;
        store_data = 1'b1;
      end else if (rx_byte_i == cfg_i.escape_byte) begin
        esc_d = 1'b1;
      end else if (rx_byte_i == cfg_i.end_byte) begin
        store_end  = 1'b1;
        idx_d      = '0;
        in_frame_d = 1'b0;
      end else begin
        store_data = 1'b1;
      end
    end
    // Drop data once the store is one short of full
    if (store_data && (idx_q < IDX_W'(FRAME_DEPTH - 1))) begin
      wr_en = 1'b1;
      idx_d = idx_q + IDX_W'(1);
    end
    if (store_end) begin
      wr_en = 1'b1;
    end
    // Only the head positions are ever read back
    for (int k = 0; k < HEAD_BYTES; k++) begin
      if (wr_en && (32'(idx_q) == k)) begin
        head_d[k] = rx_byte_i;
      end
    end
  end

  // The end byte itself is visible to decoding
  assign q_wr_o.push = store_end;
  assign q_wr_o.head = head_d;

  assign stat_o.in_frame    = in_frame_q;
  assign stat_o.esc_pending = esc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
      idx_q      <= '0;
      head_q     <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
      idx_q      <= idx_d;
      head_q     <= head_d;
    end
  end

endmodule

// File: rtl/efcd_queue.sv
// ----------------------------------------------------------------------------
// efcd_queue
// Short FIFO of closed-frame head bytes between front and back.
// ----------------------------------------------------------------------------
module efcd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  efcd_pkg::q_wr_t   q_wr_i,
  input  logic              pop_i,
  output efcd_pkg::q_rd_t   q_rd_o,
  output efcd_pkg::q_stat_t q_stat_o
);
  import efcd_pkg::*;

  head_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_q;
  logic [Q_PTR_W-1:0]  rd_ptr_q;
  logic [Q_CNT_W-1:0]  cnt_q;
  logic                push;
  logic                pop;

  assign q_stat_o.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign q_stat_o.valid = (cnt_q != '0);
  assign push           = q_wr_i.push && !q_stat_o.full;
  assign pop            = pop_i && q_stat_o.valid;

  assign q_rd_o.valid = q_stat_o.valid;
  assign q_rd_o.head  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= q_wr_i.head;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + Q_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - Q_CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/efcd_back.sv
// ----------------------------------------------------------------------------
// efcd_back
// Decodes queued frames and holds the last color in the result register.
// ----------------------------------------------------------------------------
module efcd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  efcd_pkg::cfg_t  cfg_i,
  input  efcd_pkg::q_rd_t q_rd_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output efcd_pkg::byte_t red_level_o,
  output efcd_pkg::byte_t green_level_o,
  output efcd_pkg::byte_t blue_level_o
);
  import efcd_pkg::*;

  logic  valid_q, valid_d;
  byte_t red_q, green_q, blue_q;
  logic  match;
  logic  load;

  assign match = (q_rd_i.head[POS_TYPE] == cfg_i.request_type) &&
                 (q_rd_i.head[POS_OPCODE] == cfg_i.color_opcode);

  // Take the next frame whenever the result slot is free or being emptied
  assign pop_o = q_rd_i.valid && (!valid_q || out_ready_i);
  assign load  = pop_o && match;

  always_comb begin
    valid_d = valid_q && !out_ready_i;
    if (load) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      red_q   <= '0;
      green_q <= '0;
      blue_q  <= '0;
    end else begin
      valid_q <= valid_d;
      if (load) begin
        red_q   <= q_rd_i.head[POS_RED];
        green_q <= q_rd_i.head[POS_GREEN];
        blue_q  <= q_rd_i.head[POS_BLUE];
      end
    end
  end

  assign out_valid_o   = valid_q;
  assign red_level_o   = red_q;
  assign green_level_o = green_q;
  assign blue_level_o  = blue_q;

endmodule
